// ===== design/integer_pid_controller_assert.svh =====
// Assertion macros used by the PID controller checker.
`ifndef INTEGER_PID_CONTROLLER_ASSERT_SVH
`define INTEGER_PID_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPID_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ipid: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPID_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ipid: next-cycle check failed");

`endif

// ===== design/ipid_pkg.sv =====
// Package: types, widths and constants of the integer PID controller.
`default_nettype none

package ipid_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_ON_ERROR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd6;

    // Field widths
    localparam int unsigned KIND_W = 2;
    localparam int unsigned KP_W   = 17;
    localparam int unsigned KG_W   = 32;
    localparam int unsigned LIM_W  = 15;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned MAN_W  = 8;
    localparam int unsigned DRV_W  = 8;

    // Datapath widths
    localparam int unsigned ERR_W  = VAL_W + 1;
    localparam int unsigned DERR_W = ERR_W + 1;
    localparam int unsigned MP_W   = KP_W + ERR_W;
    localparam int unsigned MAG_W  = 48;
    localparam int unsigned QUO_W  = MAG_W + 1;
    localparam int unsigned TERM_W = 50;
    localparam int unsigned ACC_W  = TERM_W + 1;

    // Constant dividers
    localparam int unsigned SCALE_PCT = 100;
    localparam int unsigned SCALE_MIL = 1000;
    localparam int unsigned DIV_SPLIT = 22;
    localparam int unsigned RECIP_W   = 32;

    // Final /100 of a clamped sum below 2^15
    localparam int unsigned DRV_RECIP_W = 13;
    localparam logic [DRV_RECIP_W-1:0] DRV_RECIP = 13'd5243;
    localparam int unsigned DRV_SHIFT = 19;
    localparam int unsigned DRV_Q_W   = LIM_W + DRV_RECIP_W - DRV_SHIFT;
    localparam logic [DRV_W-1:0] DRIVE_MAX = 8'd255;

    // Reset values
    localparam logic [LIM_W-1:0]  LIMIT_HIGH_RST    = 15'd25500;
    localparam logic [TIME_W-1:0] SAMPLE_PERIOD_RST = 16'd1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUTO    = 2'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COMPUTE,
        OP_SEED
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             auto_on;
        logic [LIM_W-1:0] seed;
    } side_t;

endpackage

`default_nettype wire

// ===== design/integer_pid_controller.sv =====
// Integer PID controller in hundredths with clamped integral and output.
//
// Items enter on the item_valid/item_ready channel and every item yields one
// result beat on result_valid/result_ready, in order. The datapath is a
// ten-register pipeline, and one item is taken every cycle while no result
// beat is held. The rate is set by the integral register, which is read,
// updated and clamped within a single stage, so consecutive items never
// wait on each other. While a result beat is held by the consumer the whole
// pipeline freezes and item_ready is low. Mode, sample-time and
// previous-sample state update at the accepting edge; the gains, limits and
// mode select are read live by the pipeline, so they must be written only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none

module integer_pid_controller
    import ipid_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  item_valid,
    output logic                 item_ready,
    input  wire [KIND_W-1:0]     kind,
    input  wire [TIME_W-1:0]     now_seconds,
    input  wire [VAL_W-1:0]      measurement,
    input  wire [VAL_W-1:0]      target,
    input  wire [MAN_W-1:0]      manual_output,

    output logic                 result_valid,
    input  wire                  result_ready,
    output logic                 computed,
    output logic [DRV_W-1:0]     drive_output,
    output logic                 auto_active,

    input  wire                  cfg_write,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned PIPE_N = 5;

    function automatic logic [LIM_W-1:0] clamp_lim(
        input logic signed [ACC_W-1:0] v,
        input logic [LIM_W-1:0]        lo,
        input logic [LIM_W-1:0]        hi
    );
        logic signed [ACC_W-1:0] lo_s;
        logic signed [ACC_W-1:0] hi_s;
        logic [LIM_W-1:0]        res;
        lo_s = $signed(ACC_W'(lo));
        hi_s = $signed(ACC_W'(hi));
        if (v > hi_s)
        begin
            res = hi;
        end
        else if (v < lo_s)
        begin
            res = lo;
        end
        else
        begin
            res = v[LIM_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic signed [KP_W-1:0] prop_gain_reg;
    logic signed [KG_W-1:0] integral_gain_reg;
    logic signed [KG_W-1:0] deriv_gain_reg;
    logic                   prop_on_error_reg;
    logic [LIM_W-1:0]       limit_low_reg;
    logic [LIM_W-1:0]       limit_high_reg;
    logic [TIME_W-1:0]      sample_period_reg;

    // controller state
    logic                    auto_mode_reg;
    logic                    auto_mode_next;
    logic [TIME_W-1:0]       prev_time_reg;
    logic [TIME_W-1:0]       prev_time_next;
    logic [VAL_W-1:0]        prev_meas_reg;
    logic [VAL_W-1:0]        prev_meas_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic [LIM_W-1:0]        integ_reg;
    logic [LIM_W-1:0]        integ_next;

    logic adv;
    logic accept;

    // front end
    logic signed [ERR_W-1:0]  err_c;
    logic signed [ERR_W-1:0]  dmeas_c;
    logic signed [DERR_W-1:0] derr_c;
    logic [TIME_W-1:0]        elapsed;
    op_t                      op_c;
    side_t                    side_c;

    // stage 1
    logic                     v1_reg;
    side_t                    side1_reg;
    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [ERR_W-1:0]  dmeas1_reg;
    logic signed [DERR_W-1:0] derr1_reg;

    // stage 2: products
    logic [ERR_W-1:0]       err_mag;
    logic [DERR_W-1:0]      derr_mag;
    logic [KP_W-1:0]        kp_mag;
    logic [KG_W-1:0]        ki_mag;
    logic [KG_W-1:0]        kd_mag;
    logic signed [MP_W-1:0] mp_c;
    logic [MAG_W-1:0]       ip_mag_reg;
    logic [MAG_W-1:0]       dp_mag_reg;
    logic [MAG_W-1:0]       pp_mag_reg;
    logic                   ip_neg_reg;
    logic                   dp_neg_reg;
    logic                   pp_neg_reg;

    // stages 2..6 sideband
    logic                   v_pipe_reg  [PIPE_N];
    side_t                  side_pipe_reg [PIPE_N];
    logic signed [MP_W-1:0] mp_pipe_reg [PIPE_N];

    logic signed [QUO_W-1:0] q_i;
    logic signed [QUO_W-1:0] q_d;
    logic signed [QUO_W-1:0] q_p;

    // stage 7: term sums
    logic signed [TERM_W-1:0] mp_eff;
    logic signed [TERM_W-1:0] pq_eff;
    logic signed [TERM_W-1:0] ti_next;
    logic signed [TERM_W-1:0] to_next;
    logic                     v7_reg;
    side_t                    side7_reg;
    logic signed [TERM_W-1:0] ti7_reg;
    logic signed [TERM_W-1:0] to7_reg;

    // stage 8: integral
    logic signed [ACC_W-1:0]  acc_c;
    logic                     v8_reg;
    side_t                    side8_reg;
    logic [LIM_W-1:0]         inew8_reg;
    logic signed [TERM_W-1:0] to8_reg;

    // stage 9: output clamp
    logic signed [ACC_W-1:0] sum_c;
    logic                    v9_reg;
    logic                    comp9_reg;
    logic                    auto9_reg;
    logic [LIM_W-1:0]        csum9_reg;

    // result register
    logic [LIM_W+DRV_RECIP_W-1:0] drv_prod;
    logic [DRV_Q_W-1:0]           drv_q;
    logic [DRV_W-1:0]             drive_next;
    logic                         out_valid_reg;
    logic                         computed_reg;
    logic [DRV_W-1:0]             drive_reg;
    logic                         auto_out_reg;

    assign adv        = !out_valid_reg || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && adv;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integral_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            prop_on_error_reg <= 1'b1;
            limit_low_reg     <= '0;
            limit_high_reg    <= LIMIT_HIGH_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= $signed(cfg_data[KP_W-1:0]);
                REG_INTEGRAL_GAIN: integral_gain_reg <= $signed(cfg_data[KG_W-1:0]);
                REG_DERIV_GAIN:    deriv_gain_reg    <= $signed(cfg_data[KG_W-1:0]);
                REG_PROP_ON_ERROR: prop_on_error_reg <= cfg_data[0];
                REG_LIMIT_LOW:     limit_low_reg     <= cfg_data[LIM_W-1:0];
                REG_LIMIT_HIGH:    limit_high_reg    <= cfg_data[LIM_W-1:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[TIME_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- front end ----------------
    assign err_c   = $signed({1'b0, target}) - $signed({1'b0, measurement});
    assign dmeas_c = $signed({1'b0, measurement}) - $signed({1'b0, prev_meas_reg});
    assign derr_c  = DERR_W'(err_c) - DERR_W'(prev_err_reg);
    assign elapsed = now_seconds - prev_time_reg;

    always_comb
    begin
        op_c           = OP_NONE;
        auto_mode_next = auto_mode_reg;
        prev_time_next = prev_time_reg;
        prev_meas_next = prev_meas_reg;
        prev_err_next  = prev_err_reg;
        unique case (kind)
            KIND_COMPUTE:
            begin
                if (auto_mode_reg && (elapsed >= sample_period_reg))
                begin
                    op_c           = OP_COMPUTE;
                    prev_time_next = now_seconds;
                    prev_meas_next = measurement;
                    prev_err_next  = err_c;
                end
            end
            KIND_AUTO:
            begin
                if (!auto_mode_reg)
                begin
                    op_c           = OP_SEED;
                    prev_meas_next = measurement;
                    prev_err_next  = '0;
                end
                auto_mode_next = 1'b1;
            end
            default:
            begin
                auto_mode_next = 1'b0;
            end
        endcase
        side_c.op      = op_c;
        side_c.auto_on = auto_mode_next;
        side_c.seed    = LIM_W'(LIM_W'(manual_output) * LIM_W'(SCALE_PCT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg <= 1'b0;
            prev_time_reg <= '0;
            prev_meas_reg <= '0;
            prev_err_reg  <= '0;
        end
        else if (accept)
        begin
            auto_mode_reg <= auto_mode_next;
            prev_time_reg <= prev_time_next;
            prev_meas_reg <= prev_meas_next;
            prev_err_reg  <= prev_err_next;
        end
    end

    // ---------------- pipeline valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PIPE_N; i++)
            begin
                v_pipe_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg        <= accept;
            v_pipe_reg[0] <= v1_reg;
            for (int i = 1; i < PIPE_N; i++)
            begin
                v_pipe_reg[i] <= v_pipe_reg[i-1];
            end
            v7_reg        <= v_pipe_reg[PIPE_N-1];
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            out_valid_reg <= v9_reg;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg  <= side_c;
            err1_reg   <= err_c;
            dmeas1_reg <= dmeas_c;
            derr1_reg  <= derr_c;
        end
    end

    // ---------------- stage 2: multiply ----------------
    assign err_mag  = err1_reg[ERR_W-1] ? ERR_W'(-err1_reg) : ERR_W'(err1_reg);
    assign derr_mag = derr1_reg[DERR_W-1] ? DERR_W'(-derr1_reg) : DERR_W'(derr1_reg);
    assign kp_mag   = prop_gain_reg[KP_W-1] ? KP_W'(-prop_gain_reg) : KP_W'(prop_gain_reg);
    assign ki_mag   = integral_gain_reg[KG_W-1] ? KG_W'(-integral_gain_reg)
                                                : KG_W'(integral_gain_reg);
    assign kd_mag   = deriv_gain_reg[KG_W-1] ? KG_W'(-deriv_gain_reg)
                                             : KG_W'(deriv_gain_reg);
    assign mp_c     = MP_W'(prop_gain_reg) * MP_W'(dmeas1_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ip_mag_reg <= MAG_W'(ki_mag) * MAG_W'(err_mag);
            dp_mag_reg <= MAG_W'(kd_mag) * MAG_W'(derr_mag);
            pp_mag_reg <= MAG_W'(kp_mag) * MAG_W'(err_mag);
            ip_neg_reg <= integral_gain_reg[KG_W-1] ^ err1_reg[ERR_W-1];
            dp_neg_reg <= deriv_gain_reg[KG_W-1] ^ derr1_reg[DERR_W-1];
            pp_neg_reg <= prop_gain_reg[KP_W-1] ^ err1_reg[ERR_W-1];
            side_pipe_reg[0] <= side1_reg;
            mp_pipe_reg[0]   <= mp_c;
            for (int i = 1; i < PIPE_N; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
                mp_pipe_reg[i]   <= mp_pipe_reg[i-1];
            end
        end
    end

    // ---------------- stages 3..6: constant dividers ----------------
    ipid_cdiv #(
        .DIV (SCALE_PCT)
    ) u_div_integral (
        .clk (clk),
        .en  (adv),
        .mag (ip_mag_reg),
        .neg (ip_neg_reg),
        .quo (q_i)
    );

    ipid_cdiv #(
        .DIV (SCALE_MIL)
    ) u_div_deriv (
        .clk (clk),
        .en  (adv),
        .mag (dp_mag_reg),
        .neg (dp_neg_reg),
        .quo (q_d)
    );

    ipid_cdiv #(
        .DIV (SCALE_PCT)
    ) u_div_prop (
        .clk (clk),
        .en  (adv),
        .mag (pp_mag_reg),
        .neg (pp_neg_reg),
        .quo (q_p)
    );

    // ---------------- stage 7: term sums ----------------
    always_comb
    begin
        if (prop_on_error_reg)
        begin
            mp_eff = '0;
            pq_eff = TERM_W'(q_p);
        end
        else
        begin
            mp_eff = TERM_W'(mp_pipe_reg[PIPE_N-1]);
            pq_eff = '0;
        end
        ti_next = TERM_W'(q_i) - mp_eff;
        to_next = TERM_W'(q_d) + pq_eff;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side7_reg <= side_pipe_reg[PIPE_N-1];
            ti7_reg   <= ti_next;
            to7_reg   <= to_next;
        end
    end

    // ---------------- stage 8: integral ----------------
    assign acc_c = $signed(ACC_W'(integ_reg)) + ACC_W'(ti7_reg);

    always_comb
    begin
        case (side7_reg.op)
            OP_SEED:    integ_next = clamp_lim($signed(ACC_W'(side7_reg.seed)),
                                               limit_low_reg, limit_high_reg);
            OP_COMPUTE: integ_next = clamp_lim(acc_c, limit_low_reg, limit_high_reg);
            default:    integ_next = integ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (adv && v7_reg)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side8_reg <= side7_reg;
            inew8_reg <= integ_next;
            to8_reg   <= to7_reg;
        end
    end

    // ---------------- stage 9: output clamp ----------------
    assign sum_c = $signed(ACC_W'(inew8_reg)) + ACC_W'(to8_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            comp9_reg <= (side8_reg.op == OP_COMPUTE);
            auto9_reg <= side8_reg.auto_on;
            csum9_reg <= clamp_lim(sum_c, limit_low_reg, limit_high_reg);
        end
    end

    // ---------------- result register ----------------
    assign drv_prod = (LIM_W+DRV_RECIP_W)'(csum9_reg) * (LIM_W+DRV_RECIP_W)'(DRV_RECIP);
    assign drv_q    = drv_prod[LIM_W+DRV_RECIP_W-1:DRV_SHIFT];

    always_comb
    begin
        if (!comp9_reg)
        begin
            drive_next = '0;
        end
        else if (drv_q > DRV_Q_W'(DRIVE_MAX))
        begin
            drive_next = DRIVE_MAX;
        end
        else
        begin
            drive_next = drv_q[DRV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            computed_reg <= comp9_reg;
            drive_reg    <= drive_next;
            auto_out_reg <= auto9_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign computed     = computed_reg;
    assign drive_output = drive_reg;
    assign auto_active  = auto_out_reg;

endmodule

`default_nettype wire

// ===== design/ipid_cdiv.sv =====
// Pipelined signed division by a constant, truncating toward zero (4 stages).
`default_nettype none

module ipid_cdiv
    import ipid_pkg::*;
#(
    parameter int unsigned DIV = SCALE_PCT
)
(
    input  wire                     clk,
    input  wire                     en,
    input  wire [MAG_W-1:0]         mag,
    input  wire                     neg,
    output logic signed [QUO_W-1:0] quo
);

    localparam int unsigned HW = MAG_W - DIV_SPLIT;
    localparam int unsigned RW = $clog2(DIV);
    localparam int unsigned TW = RW + DIV_SPLIT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / DIV);

    // stage a: estimate of high-part quotient
    logic [HW+RECIP_W-1:0] prod_h;
    logic [HW-1:0]         h_reg;
    logic [HW-1:0]         qh0_reg;
    logic [DIV_SPLIT-1:0]  l_reg;
    logic                  neg_a_reg;

    // stage b: corrected high quotient, remainder joined with low part
    logic [HW-1:0] rh0;
    logic [HW-1:0] qh_next;
    logic [RW-1:0] rh_next;
    logic [HW-1:0] qh_reg;
    logic [TW-1:0] t_reg;
    logic          neg_b_reg;

    // stage c: estimate of low quotient
    logic [TW+RECIP_W-1:0] prod_t;
    logic [TW-1:0]         qt0_reg;
    logic [TW-1:0]         t_c_reg;
    logic [HW-1:0]         qh_c_reg;
    logic                  neg_c_reg;

    // stage d: correction, merge and sign
    logic [TW-1:0]            rt0;
    logic [TW-1:0]            qt;
    logic [MAG_W-1:0]         q_mag;
    logic signed [QUO_W-1:0]  quo_next;
    logic signed [QUO_W-1:0]  quo_reg;

    assign prod_h = (HW+RECIP_W)'(mag[MAG_W-1:DIV_SPLIT]) * (HW+RECIP_W)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg     <= mag[MAG_W-1:DIV_SPLIT];
            l_reg     <= mag[DIV_SPLIT-1:0];
            qh0_reg   <= prod_h[HW+RECIP_W-1:RECIP_W];
            neg_a_reg <= neg;
        end
    end

    always_comb
    begin
        rh0 = h_reg - HW'(qh0_reg * HW'(DIV));
        if (rh0 >= HW'(DIV))
        begin
            qh_next = qh0_reg + HW'(1);
            rh_next = RW'(rh0 - HW'(DIV));
        end
        else
        begin
            qh_next = qh0_reg;
            rh_next = RW'(rh0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qh_reg    <= qh_next;
            t_reg     <= {rh_next, l_reg};
            neg_b_reg <= neg_a_reg;
        end
    end

    assign prod_t = (TW+RECIP_W)'(t_reg) * (TW+RECIP_W)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qt0_reg   <= prod_t[TW+RECIP_W-1:RECIP_W];
            t_c_reg   <= t_reg;
            qh_c_reg  <= qh_reg;
            neg_c_reg <= neg_b_reg;
        end
    end

    always_comb
    begin
        rt0 = t_c_reg - TW'(qt0_reg * TW'(DIV));
        if (rt0 >= TW'(DIV))
        begin
            qt = qt0_reg + TW'(1);
        end
        else
        begin
            qt = qt0_reg;
        end
        q_mag = {qh_c_reg, DIV_SPLIT'(0)} + MAG_W'(qt);
        if (neg_c_reg)
        begin
            quo_next = -$signed({1'b0, q_mag});
        end
        else
        begin
            quo_next = $signed({1'b0, q_mag});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ===== design/ipid_checker.sv =====
// Port-level checker for the PID controller and its bind.
`default_nettype none

`include "integer_pid_controller_assert.svh"

module ipid_checker
    import ipid_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  item_ready,
    input wire                  result_valid,
    input wire                  result_ready,
    input wire                  computed,
    input wire [DRV_W-1:0]      drive_output,
    input wire                  auto_active
);

    // a held result beat stays offered
    `IPID_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)

    // a held result freezes the pipeline, so no new beat is taken
    `IPID_ASSERT_IMPLIES(a_stall_blocks_item, clk, rst_n, result_valid && !result_ready, !item_ready)

    // no fresh drive value means the field reads zero
    `IPID_ASSERT_IMPLIES(a_idle_drive_zero, clk, rst_n, result_valid && !computed, drive_output == '0)

    // computation happens only in automatic mode
    `IPID_ASSERT_IMPLIES(a_compute_in_auto, clk, rst_n, result_valid && computed, auto_active)

endmodule

bind integer_pid_controller ipid_checker u_ipid_checker (.*);

`default_nettype wire
